/* src/assert_macros.svh */
// Concurrent assertion helpers for the double tap detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DTD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dtd: same-cycle check failed");

// Next-cycle implication.
`define DTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtd: next-cycle check failed");

`endif

/* src/dtd_pkg.sv */
package dtd_pkg;

  localparam int PosW   = 12;
  localparam int TsW    = 32;
  localparam int DurW   = 16;
  localparam int DistW  = 12;
  localparam int LimSqW = 2 * DistW;
  localparam int CfgIdxW = 1;

  localparam logic [DurW-1:0]   DurReset   = DurW'(300);
  localparam logic [LimSqW-1:0] LimSqReset = LimSqW'(64 * 64);

  typedef enum logic [1:0] {
    CMD_PRESS   = 2'd0,
    CMD_MOVE    = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_OTHER   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CODE_NONE   = 2'd0,
    CODE_START  = 2'd1,
    CODE_ACTION = 2'd2
  } gesture_code_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_DURATION = 1'b0,
    REG_MAX_DISTANCE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]     cmd;
    logic           single_pointer;
    logic [PosW-1:0] pos_x;
    logic [PosW-1:0] pos_y;
    logic [TsW-1:0] timestamp_ms;
  } dt_in_t;

  typedef struct packed {
    logic [1:0] gesture_code;
    logic       double_tap;
  } dt_out_t;

  typedef struct packed {
    logic [DurW-1:0]   dur_ms;
    logic [LimSqW-1:0] lim_sq;
  } dtd_cfg_t;

endpackage

/* src/double_tap_detector_top.sv */
// Path: the input register, then the result register; the result register loads when the
// item leaves the input register, which waits while a held result is not yet taken.
// Throughput: 1 item per cycle unless a held result stalls; phase and first-press registers
// update in the same cycle an item leaves the input register, so the next item sees them at once.
// Reset (rst_ni low, async): phase ready, first press zero, max duration 300 ms,
// max distance 64 px, both stages empty.
`include "assert_macros.svh"

module double_tap_detector_top import dtd_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dt_in_t             in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dt_out_t            out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DurW-1:0]    cfg_wdata_i
);

  localparam int CoordW = (COORD_BITS < PosW) ? COORD_BITS : PosW;

  dt_in_t        in_q;
  logic          in_valid_q;
  dt_out_t       out_q, out_d;
  logic          out_valid_q;
  logic          advance;
  dtd_cfg_t      cfg_q;
  gesture_code_e code;
  logic [DistW-1:0] dist_wdata;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign dist_wdata = cfg_wdata_i[DistW-1:0];

  dtd_fsm #(.CoordW(CoordW)) u_fsm (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .item_i(in_q),
    .cfg_i (cfg_q),
    .code_o(code)
  );

  always_comb begin
    out_d.gesture_code = code;
    out_d.double_tap   = (code == CODE_ACTION);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dur_ms <= DurReset;
      cfg_q.lim_sq <= LimSqReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MAX_DURATION: cfg_q.dur_ms <= cfg_wdata_i;
        REG_MAX_DISTANCE: cfg_q.lim_sq <= LimSqW'(dist_wdata) * LimSqW'(dist_wdata);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `DTD_ASSERT_NOW(a_flag_matches_code, clk_i, rst_ni, out_valid_o,
                  out_data_o.double_tap == (out_data_o.gesture_code == CODE_ACTION))
  `DTD_ASSERT_NOW(a_code_in_range, clk_i, rst_ni, out_valid_o,
                  (out_data_o.gesture_code == CODE_NONE) ||
                  (out_data_o.gesture_code == CODE_START) ||
                  (out_data_o.gesture_code == CODE_ACTION))
  `DTD_ASSERT_NEXT(a_item_moves_to_result, clk_i, rst_ni, in_valid_q && !out_valid_q,
                   out_valid_q)
  `DTD_ASSERT_NOW(a_stall_only_when_full, clk_i, rst_ni, !in_ready_o,
                  in_valid_q && out_valid_q && !out_ready_i)

endmodule

/* src/dtd_dist.sv */
module dtd_dist import dtd_pkg::*; #(
  parameter int CoordW = 12
) (
  input  logic [CoordW-1:0] a_x_i,
  input  logic [CoordW-1:0] a_y_i,
  input  logic [CoordW-1:0] b_x_i,
  input  logic [CoordW-1:0] b_y_i,
  input  logic [LimSqW-1:0] lim_sq_i,
  output logic              within_o
);

  localparam int SumW = 2 * CoordW + 1;
  localparam int SqW  = (SumW > LimSqW) ? SumW : LimSqW;

  logic [CoordW-1:0]   dx, dy;
  logic [2*CoordW-1:0] sq_x, sq_y;
  logic [SumW-1:0]     sum;

  always_comb begin
    dx   = (a_x_i >= b_x_i) ? (a_x_i - b_x_i) : (b_x_i - a_x_i);
    dy   = (a_y_i >= b_y_i) ? (a_y_i - b_y_i) : (b_y_i - a_y_i);
    sq_x = (2*CoordW)'(dx) * (2*CoordW)'(dx);
    sq_y = (2*CoordW)'(dy) * (2*CoordW)'(dy);
    sum  = {1'b0, sq_x} + {1'b0, sq_y};
    within_o = SqW'(sum) <= SqW'(lim_sq_i);
  end

endmodule

/* src/dtd_fsm.sv */
module dtd_fsm import dtd_pkg::*; #(
  parameter int CoordW = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  dt_in_t        item_i,
  input  dtd_cfg_t      cfg_i,
  output gesture_code_e code_o
);

  typedef enum logic [1:0] {
    PH_READY    = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_RELEASED = 2'd2,
    PH_PRESSED2 = 2'd3
  } phase_e;

  phase_e            phase_q, phase_d, eff_phase;
  logic [TsW-1:0]    first_time_q;
  logic [CoordW-1:0] first_x_q, first_y_q;
  logic [CoordW-1:0] x, y;
  logic [TsW-1:0]    delta;
  logic              expired, in_reach, capture;
  cmd_e              cmd;

  assign x   = item_i.pos_x[CoordW-1:0];
  assign y   = item_i.pos_y[CoordW-1:0];
  assign cmd = cmd_e'(item_i.cmd);

  dtd_dist #(.CoordW(CoordW)) u_dist (
    .a_x_i   (x),
    .a_y_i   (y),
    .b_x_i   (first_x_q),
    .b_y_i   (first_y_q),
    .lim_sq_i(cfg_i.lim_sq),
    .within_o(in_reach)
  );

  always_comb begin
    delta     = item_i.timestamp_ms - first_time_q;
    expired   = (phase_q != PH_READY) && (delta > TsW'(cfg_i.dur_ms));
    eff_phase = expired ? PH_READY : phase_q;
    phase_d   = PH_READY;
    code_o    = CODE_NONE;
    capture   = 1'b0;
    if (item_i.single_pointer && !(expired && cmd != CMD_PRESS)) begin
      unique case (cmd)
        CMD_PRESS: begin
          if (eff_phase == PH_READY) begin
            capture = 1'b1;
            phase_d = PH_PRESSED;
            code_o  = CODE_START;
          end else if (eff_phase == PH_RELEASED && in_reach) begin
            phase_d = PH_PRESSED2;
            code_o  = CODE_START;
          end
        end
        CMD_RELEASE: begin
          if (eff_phase == PH_PRESSED) begin
            phase_d = PH_RELEASED;
            code_o  = CODE_START;
          end else if (eff_phase == PH_PRESSED2 && in_reach) begin
            code_o  = CODE_ACTION;
          end
        end
        CMD_MOVE: begin
          if (eff_phase != PH_READY && in_reach) begin
            phase_d = eff_phase;
            code_o  = CODE_START;
          end
        end
        default: begin
          phase_d = PH_READY;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_READY;
      first_time_q <= '0;
      first_x_q    <= '0;
      first_y_q    <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      if (capture) begin
        first_time_q <= item_i.timestamp_ms;
        first_x_q    <= x;
        first_y_q    <= y;
      end
    end
  end

endmodule

/* tb/double_tap_checker.sv */
module double_tap_checker import dtd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  dt_in_t             in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  dt_out_t            out_data_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DurW-1:0]    cfg_wdata_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    TAP_IDLE,
    TAP_DOWN,
    TAP_UP,
    TAP_DOWN_AGAIN
  } tap_phase_e;

  tap_phase_e      tap_phase;
  logic [TsW-1:0]  first_ts;
  logic [PosW-1:0] first_x;
  logic [PosW-1:0] first_y;
  logic [DurW-1:0] dur_limit;
  logic [DistW-1:0] dist_limit;

  dt_out_t       expected_results[$];
  dt_out_t       oldest;
  dt_out_t       predicted;
  gesture_code_e touch_code;

  initial fail_count_o = 0;
  initial pending_o = 0;

  task automatic report(string msg);
    if (fail_count_o < 50) $display("[%0t] %s", $time, msg);
    fail_count_o++;
  endtask

  // squared distance compare, exact
  function automatic bit near_first(logic [PosW-1:0] x, logic [PosW-1:0] y);
    longint unsigned dx, dy, lim;
    dx = (x >= first_x) ? longint'(x - first_x) : longint'(first_x - x);
    dy = (y >= first_y) ? longint'(y - first_y) : longint'(first_y - y);
    lim = longint'(dist_limit);
    return dx * dx + dy * dy <= lim * lim;
  endfunction

  function automatic gesture_code_e classify_touch(dt_in_t ev);
    logic [TsW-1:0] elapsed;
    bit ok;
    elapsed = ev.timestamp_ms - first_ts;
    if (!ev.single_pointer) begin
      tap_phase = TAP_IDLE;
      return CODE_NONE;
    end
    if (tap_phase != TAP_IDLE && elapsed > TsW'(dur_limit)) begin
      tap_phase = TAP_IDLE;
      if (cmd_e'(ev.cmd) != CMD_PRESS) return CODE_NONE;
    end
    case (cmd_e'(ev.cmd))
      CMD_PRESS: begin
        if (tap_phase == TAP_IDLE) begin
          first_ts = ev.timestamp_ms;
          first_x = ev.pos_x;
          first_y = ev.pos_y;
          tap_phase = TAP_DOWN;
          return CODE_START;
        end
        if (tap_phase == TAP_UP) begin
          if (!near_first(ev.pos_x, ev.pos_y)) begin
            tap_phase = TAP_IDLE;
            return CODE_NONE;
          end
          tap_phase = TAP_DOWN_AGAIN;
          return CODE_START;
        end
        tap_phase = TAP_IDLE;
        return CODE_NONE;
      end
      CMD_RELEASE: begin
        if (tap_phase == TAP_DOWN) begin
          tap_phase = TAP_UP;
          return CODE_START;
        end
        if (tap_phase == TAP_DOWN_AGAIN) begin
          ok = near_first(ev.pos_x, ev.pos_y);
          tap_phase = TAP_IDLE;
          return ok ? CODE_ACTION : CODE_NONE;
        end
        tap_phase = TAP_IDLE;
        return CODE_NONE;
      end
      CMD_MOVE: begin
        if (tap_phase != TAP_IDLE && near_first(ev.pos_x, ev.pos_y)) return CODE_START;
        tap_phase = TAP_IDLE;
        return CODE_NONE;
      end
      default: begin
        tap_phase = TAP_IDLE;
        return CODE_NONE;
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_phase = TAP_IDLE;
      first_ts = '0;
      first_x = '0;
      first_y = '0;
      dur_limit = DurReset;
      dist_limit = DistW'(64);
      expected_results.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_MAX_DURATION: dur_limit = cfg_wdata_i;
          REG_MAX_DISTANCE: dist_limit = cfg_wdata_i[DistW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report($sformatf("result code %0d with no item pending", out_data_i.gesture_code));
        end else begin
          oldest = expected_results.pop_front();
          if (out_data_i.gesture_code !== oldest.gesture_code)
            report($sformatf("gesture_code: expected %0d, got %0d",
                             oldest.gesture_code, out_data_i.gesture_code));
          if (out_data_i.double_tap !== oldest.double_tap)
            report($sformatf("double_tap: expected %0d, got %0d",
                             oldest.double_tap, out_data_i.double_tap));
        end
      end
      if (in_valid_i && in_ready_i) begin
        touch_code = classify_touch(in_data_i);
        predicted.gesture_code = touch_code;
        predicted.double_tap = (touch_code == CODE_ACTION);
        expected_results = {expected_results, predicted};
      end
      pending_o = expected_results.size();
    end
  end

endmodule

/* tb/double_tap_detector_top_test.sv */
module double_tap_detector_top_test import dtd_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomPerPhase = 255;
  localparam int CycleLimit     = 200000;
  localparam int DrainCycles    = 6;
  localparam int LongHold       = 80;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  dt_in_t             in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  dt_out_t            out_data_o;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [DurW-1:0]    cfg_wdata_i = '0;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int sent = 0;
  int results_taken = 0;
  bit tx_calm = 0;
  bit rx_calm = 0;
  int cur_dur = 300;
  int cur_dist = 64;
  logic [TsW-1:0] clock_ms;

  double_tap_detector_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  double_tap_checker tap_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic push_touch(cmd_e cmd, bit single, int x, int y, logic [TsW-1:0] ts);
    int gap;
    dt_in_t ev;
    gap = tx_calm ? 0 : $urandom_range(0, 5);
    ev.cmd = cmd;
    ev.single_pointer = single;
    ev.pos_x = PosW'(x);
    ev.pos_y = PosW'(y);
    ev.timestamp_ms = ts;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= ev;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    sent++;
    if (sent % 50 == 0) tx_calm = ($urandom_range(0, 3) == 0);
  endtask

  function automatic int jitter(int base);
    int spread, v;
    spread = ($urandom_range(0, 5) == 0) ? cur_dist + cur_dist / 2 + 2 : (cur_dist * 7) / 10;
    v = base + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v;
  endfunction

  task automatic step_time();
    if ($urandom_range(0, 19) == 0)
      clock_ms = clock_ms + TsW'(cur_dur + 1 + $urandom_range(0, 100));
    else
      clock_ms = clock_ms + TsW'($urandom_range(0, cur_dur / 4));
  endtask

  task automatic noise_touch();
    if ($urandom_range(0, 7) == 0) clock_ms = $urandom;
    else clock_ms = clock_ms + TsW'($urandom_range(0, 2 * cur_dur + 1));
    push_touch(cmd_e'($urandom_range(0, 3)), $urandom_range(0, 4) != 0,
               $urandom_range(0, 4095), $urandom_range(0, 4095), clock_ms);
  endtask

  task automatic follow_up(cmd_e cmd, int bx, int by);
    if ($urandom_range(0, 9) == 0) noise_touch();
    step_time();
    push_touch(cmd, 1'b1, jitter(bx), jitter(by), clock_ms);
  endtask

  task automatic play_double_tap();
    int bx, by;
    bx = $urandom_range(0, 4095);
    by = $urandom_range(0, 4095);
    step_time();
    push_touch(CMD_PRESS, 1'b1, bx, by, clock_ms);
    repeat ($urandom_range(0, 2)) follow_up(CMD_MOVE, bx, by);
    follow_up(CMD_RELEASE, bx, by);
    follow_up(CMD_PRESS, bx, by);
    repeat ($urandom_range(0, 2)) follow_up(CMD_MOVE, bx, by);
    follow_up(CMD_RELEASE, bx, by);
  endtask

  task automatic run_random(int n);
    int start;
    start = sent;
    while (sent - start < n) begin
      if ($urandom_range(0, 9) < 7) play_double_tap();
      else noise_touch();
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [DurW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(int dur, int dist_px);
    drain();
    write_reg(REG_MAX_DURATION, DurW'(dur));
    // upper bits beyond the distance width must be dropped
    write_reg(REG_MAX_DISTANCE, {4'($urandom_range(0, 15)), DistW'(dist_px)});
    cur_dur = dur;
    cur_dist = dist_px;
  endtask

  task automatic directed();
    logic [TsW-1:0] t;
    t = 32'hFFFF_FF00;
    push_touch(CMD_PRESS,   1'b1, 100, 100, t);
    push_touch(CMD_RELEASE, 1'b1, 100, 100, t + 10);
    push_touch(CMD_PRESS,   1'b1, 130, 100, t + 20);
    push_touch(CMD_MOVE,    1'b1, 100, 160, t + 30);
    // exactly at max distance, timestamp wrapped
    push_touch(CMD_RELEASE, 1'b1, 100, 164, t + 290);
    push_touch(CMD_RELEASE, 1'b1, 5, 5, t + 300);
    push_touch(CMD_MOVE,    1'b1, 5, 5, t + 300);
    t = 32'd1000;
    push_touch(CMD_PRESS,   1'b1, 0, 0, t);
    push_touch(CMD_OTHER,   1'b1, 0, 0, t + 1);
    push_touch(CMD_PRESS,   1'b1, 0, 0, t + 2);
    push_touch(CMD_PRESS,   1'b1, 0, 0, t + 3);
    push_touch(CMD_PRESS,   1'b1, 4095, 4095, t + 10);
    push_touch(CMD_MOVE,    1'b1, 0, 0, t + 11);
    push_touch(CMD_PRESS,   1'b1, 4095, 0, t + 20);
    push_touch(CMD_RELEASE, 1'b1, 4095, 0, t + 25);
    push_touch(CMD_RELEASE, 1'b1, 4095, 0, t + 26);
    push_touch(CMD_PRESS,   1'b1, 4095, 0, t + 30);
    push_touch(CMD_RELEASE, 1'b1, 4095, 0, t + 31);
    push_touch(CMD_PRESS,   1'b1, 0, 4095, t + 32);
    push_touch(CMD_PRESS,   1'b1, 10, 10, t + 40);
    push_touch(CMD_RELEASE, 1'b1, 10, 10, t + 41);
    push_touch(CMD_PRESS,   1'b1, 10, 10, t + 42);
    push_touch(CMD_RELEASE, 1'b1, 200, 10, t + 43);
    push_touch(CMD_PRESS,   1'b1, 20, 20, t + 50);
    push_touch(CMD_RELEASE, 1'b1, 20, 20, t + 351);
    push_touch(CMD_PRESS,   1'b1, 20, 20, t + 400);
    push_touch(CMD_RELEASE, 1'b1, 20, 20, t + 401);
    push_touch(CMD_PRESS,   1'b1, 30, 30, t + 800);
    push_touch(CMD_MOVE,    1'b0, 30, 30, t + 801);
  endtask

  // result side: random stalls, plus long hold-offs that back up the block
  initial begin
    int hold;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (results_taken == 400 || results_taken == 1100) hold = LongHold;
      else hold = rx_calm ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
      results_taken++;
      if (results_taken % 40 == 0) rx_calm = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    clock_ms = $urandom;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    directed();
    run_random(RandomPerPhase);
    configure(65535, 4095);
    run_random(RandomPerPhase);
    configure(0, 0);
    run_random(RandomPerPhase);
    configure(1000, 200);
    run_random(RandomPerPhase);
    configure($urandom_range(0, 65535), $urandom_range(0, 4095));
    run_random(RandomPerPhase);
    configure(150, 16);
    run_random(RandomPerPhase);
    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
